// ===== rtl/drab_pkg.sv =====
// Shared types, codes and constants for the DMA rectangular address/burst generator.
// Used by drab_side and dma_rect_address_burst_gen; no dependencies.
`default_nettype none

package drab_pkg;

    // Request command codes (s_axis_tuser)
    localparam logic [1:0] CMD_START   = 2'd0;
    localparam logic [1:0] CMD_READ    = 2'd1;
    localparam logic [1:0] CMD_WRITE   = 2'd2;
    localparam logic [1:0] CMD_UNKNOWN = 2'd3;

    // Result status codes (m_axis_tuser)
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_INVALID  = 2'd1;
    localparam logic [1:0] STATUS_INACTIVE = 2'd2;

    // Addressing modes
    localparam logic [1:0] MODE_LINEAR    = 2'd0;
    localparam logic [1:0] MODE_FIXED     = 2'd1;
    localparam logic [1:0] MODE_RECT      = 2'd2;
    localparam logic [1:0] MODE_UNDEFINED = 2'd3;

    // Burst size codes, in bus units
    localparam logic [1:0] BURST_CODE_4   = 2'd0;
    localparam logic [1:0] BURST_CODE_8   = 2'd1;
    localparam logic [1:0] BURST_CODE_16  = 2'd2;
    localparam logic [1:0] BURST_CODE_BAD = 2'd3;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_BURST_CODE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDE_BUS    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_MODE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DEST_MODE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RECT_ENABLE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_WIDTH  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_STEP    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_DST_STEP    = 3'd7;

    // Local-bus windows and rebase offset
    localparam logic [31:0] LOCAL_LO_A   = 32'h0020_0000;
    localparam logic [31:0] LOCAL_HI_A   = 32'h002f_ffff;
    localparam logic [31:0] LOCAL_LO_B   = 32'h0060_0000;
    localparam logic [31:0] LOCAL_HI_B   = 32'h006f_ffff;
    localparam logic [31:0] LOCAL_REBASE = 32'h0020_0000;

    // One side's walking state: current address, line start, bytes left on the line
    typedef struct packed {
        logic [31:0] cur;
        logic [31:0] base;
        logic [31:0] left;
    } side_t;

    function automatic logic is_local(input logic [31:0] addr);
        is_local = ((addr >= LOCAL_LO_A) && (addr <= LOCAL_HI_A)) ||
                   ((addr >= LOCAL_LO_B) && (addr <= LOCAL_HI_B));
    endfunction

endpackage

`default_nettype wire

// ===== rtl/dma_rect_address_burst_gen.sv =====
// DMA channel address and burst-length generator, top level.
// Depends on drab_pkg and drab_side.
//
//  Channel   Dir  tuser                 tdata (lowest bit up)
//  s_axis    in   [1:0] command         start_source, start_dest, byte_count, buffered_bytes
//  m_axis    out  [1:0] status          burst_bytes, bus_address, on_local_bus,
//                                       reads_finished, bytes_remaining, transfer_done
//  cfg       in   -                     cfg_index selects register, cfg_data written
//
// A request is evaluated against the channel state as it is
// accepted and its result lands in the output register on the same edge, so a new
// request is taken every cycle while m_axis_tready is high. The output register is
// the only stall point: s_axis_tready drops only while a result waits unaccepted.
// Reset (aresetn, synchronous) clears the channel to inactive with the read flag set.
`default_nettype none

module dma_rect_address_burst_gen import drab_pkg::*; (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // request stream
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [103:0]         s_axis_tdata,  // start_source, start_dest, byte_count, buffered_bytes
    input  wire logic [1:0]           s_axis_tuser,  // command
    // result stream
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    output logic [79:0]               m_axis_tdata,  // burst_bytes, bus_address, on_local_bus,
                                                     // reads_finished, bytes_remaining,
                                                     // transfer_done, zero pad
    output logic [1:0]                m_axis_tuser,  // status
    // configuration writes
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [15:0]          cfg_data
);

    // Configuration registers
    logic [1:0]  burst_code_reg;
    logic        wide_bus_reg;
    logic [1:0]  src_mode_reg;
    logic [1:0]  dst_mode_reg;
    logic        rect_en_reg;
    logic [15:0] line_width_reg;
    logic [15:0] src_step_reg;
    logic [15:0] dst_step_reg;

    // Channel state
    side_t       src_reg, src_next;
    side_t       dst_reg, dst_next;
    logic [31:0] count_reg, count_next;
    logic        rd_done_reg, rd_done_next;
    logic        active_reg, active_next;

    // Result register
    logic        out_valid_reg;
    logic [1:0]  out_status_reg, out_status_next;
    logic [7:0]  out_len_reg, out_len_next;
    logic [31:0] out_addr_reg, out_addr_next;
    logic        out_local_reg, out_local_next;
    logic        out_rfin_reg, out_rfin_next;
    logic        out_done_reg, out_done_next;

    // Request fields
    logic [1:0]  req_cmd;
    logic [31:0] req_src;
    logic [31:0] req_dst;
    logic [31:0] req_count;
    logic [7:0]  req_buffered;
    logic        req_accept;

    logic [7:0]  full_burst;
    logic [15:0] unit_bytes;
    logic        cfg_ok;
    logic        any_rect;
    logic [7:0]  src_len, dst_len;
    side_t       src_adv, dst_adv;
    logic [31:0] src_line_len, dst_line_len;
    logic [31:0] burst_addr;

    assign req_cmd      = s_axis_tuser;
    assign req_src      = s_axis_tdata[31:0];
    assign req_dst      = s_axis_tdata[63:32];
    assign req_count    = s_axis_tdata[95:64];
    assign req_buffered = s_axis_tdata[103:96];

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign req_accept    = s_axis_tvalid && s_axis_tready;

    // Configuration write port
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            burst_code_reg <= BURST_CODE_4;
            wide_bus_reg   <= 1'b0;
            src_mode_reg   <= MODE_LINEAR;
            dst_mode_reg   <= MODE_LINEAR;
            rect_en_reg    <= 1'b0;
            line_width_reg <= 16'd0;
            src_step_reg   <= 16'd0;
            dst_step_reg   <= 16'd0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_BURST_CODE:  burst_code_reg <= cfg_data[1:0];
                CFG_WIDE_BUS:    wide_bus_reg   <= cfg_data[0];
                CFG_SOURCE_MODE: src_mode_reg   <= cfg_data[1:0];
                CFG_DEST_MODE:   dst_mode_reg   <= cfg_data[1:0];
                CFG_RECT_ENABLE: rect_en_reg    <= cfg_data[0];
                CFG_LINE_WIDTH:  line_width_reg <= cfg_data;
                CFG_SRC_STEP:    src_step_reg   <= cfg_data;
                CFG_DST_STEP:    dst_step_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // Full burst size in bytes and configuration check
    always_comb begin
        unit_bytes = wide_bus_reg ? 16'd8 : 16'd4;
        case (burst_code_reg)
            BURST_CODE_4: full_burst = wide_bus_reg ? 8'd32 : 8'd16;
            BURST_CODE_8: full_burst = wide_bus_reg ? 8'd64 : 8'd32;
            default:      full_burst = wide_bus_reg ? 8'd128 : 8'd64;
        endcase
        any_rect = (src_mode_reg == MODE_RECT) || (dst_mode_reg == MODE_RECT);
        cfg_ok   = 1'b1;
        if ((burst_code_reg == BURST_CODE_BAD) ||
            ((burst_code_reg == BURST_CODE_16) && wide_bus_reg))
            cfg_ok = 1'b0;
        if ((src_mode_reg == MODE_UNDEFINED) || (dst_mode_reg == MODE_UNDEFINED))
            cfg_ok = 1'b0;
        if (any_rect) begin
            if (!rect_en_reg || (line_width_reg < unit_bytes))
                cfg_ok = 1'b0;
            if ((src_mode_reg == MODE_RECT) && (src_step_reg < line_width_reg))
                cfg_ok = 1'b0;
            if ((dst_mode_reg == MODE_RECT) && (dst_step_reg < line_width_reg))
                cfg_ok = 1'b0;
        end
    end

    // Source and destination burst units
    drab_side u_src (
        .cur_side   (src_reg),
        .mode       (src_mode_reg),
        .line_step  (src_step_reg),
        .line_width (line_width_reg),
        .full_burst (full_burst),
        .limit      (count_reg),
        .count_left (count_reg),
        .burst_len  (src_len),
        .next_side  (src_adv)
    );

    drab_side u_dst (
        .cur_side   (dst_reg),
        .mode       (dst_mode_reg),
        .line_step  (dst_step_reg),
        .line_width (line_width_reg),
        .full_burst (full_burst),
        .limit      ({24'd0, req_buffered}),
        .count_left (count_reg),
        .burst_len  (dst_len),
        .next_side  (dst_adv)
    );

    // Initial line length at start: line width (rect), full burst (fixed), else the new byte count
    always_comb begin
        case (src_mode_reg)
            MODE_RECT:  src_line_len = {16'd0, line_width_reg};
            MODE_FIXED: src_line_len = {24'd0, full_burst};
            default:    src_line_len = req_count;
        endcase
        case (dst_mode_reg)
            MODE_RECT:  dst_line_len = {16'd0, line_width_reg};
            MODE_FIXED: dst_line_len = {24'd0, full_burst};
            default:    dst_line_len = req_count;
        endcase
    end

    // Request decode: next channel state and result fields
    always_comb begin
        src_next        = src_reg;
        dst_next        = dst_reg;
        count_next      = count_reg;
        rd_done_next    = rd_done_reg;
        active_next     = active_reg;
        out_status_next = STATUS_OK;
        out_len_next    = 8'd0;
        burst_addr      = 32'd0;
        out_rfin_next   = 1'b0;
        out_done_next   = 1'b0;

        case (req_cmd)
            CMD_START: begin
                if (!active_reg) begin
                    if (!cfg_ok) begin
                        out_status_next = STATUS_INVALID;
                    end else begin
                        count_next    = req_count;
                        src_next.cur  = req_src;
                        src_next.base = req_src;
                        src_next.left = src_line_len;
                        dst_next.cur  = req_dst;
                        dst_next.base = req_dst;
                        dst_next.left = dst_line_len;
                        rd_done_next  = 1'b0;
                        active_next   = 1'b1;
                    end
                end
            end
            CMD_READ: begin
                if (!active_reg) begin
                    out_status_next = STATUS_INACTIVE;
                end else if (!cfg_ok) begin
                    out_status_next = STATUS_INVALID;
                end else begin
                    burst_addr   = src_reg.cur;
                    out_len_next = src_len;
                    src_next     = src_adv;
                    if ({24'd0, src_len} >= count_reg)
                        rd_done_next = 1'b1;
                    out_rfin_next = rd_done_next;
                end
            end
            CMD_WRITE: begin
                if (!active_reg) begin
                    out_status_next = STATUS_INACTIVE;
                end else if (!cfg_ok) begin
                    out_status_next = STATUS_INVALID;
                end else begin
                    burst_addr   = dst_reg.cur;
                    out_len_next = dst_len;
                    dst_next     = dst_adv;
                    // saturate the count at zero
                    if ({24'd0, dst_len} >= count_reg) begin
                        count_next    = 32'd0;
                        out_done_next = 1'b1;
                        active_next   = 1'b0;
                    end else begin
                        count_next = count_reg - {24'd0, dst_len};
                    end
                end
            end
            default: begin
                out_status_next = STATUS_INVALID;
            end
        endcase

        // Local-bus decode and rebase of the burst address
        out_local_next = is_local(burst_addr);
        out_addr_next  = out_local_next ? burst_addr - LOCAL_REBASE : burst_addr;
    end

    // Channel state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_reg     <= '0;
            dst_reg     <= '0;
            count_reg   <= 32'd0;
            rd_done_reg <= 1'b1;
            active_reg  <= 1'b0;
        end else if (req_accept) begin
            src_reg     <= src_next;
            dst_reg     <= dst_next;
            count_reg   <= count_next;
            rd_done_reg <= rd_done_next;
            active_reg  <= active_next;
        end
    end

    // Result register valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (req_accept) begin
            out_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result register payload
    always_ff @(posedge aclk) begin
        if (req_accept) begin
            out_status_reg <= out_status_next;
            out_len_reg    <= out_len_next;
            out_addr_reg   <= out_addr_next;
            out_local_reg  <= out_local_next;
            out_rfin_reg   <= out_rfin_next;
            out_done_reg   <= out_done_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tdata  = {5'd0, out_done_reg, count_reg, out_rfin_reg, out_local_reg,
                            out_addr_reg, out_len_reg};

endmodule

`default_nettype wire

// ===== rtl/drab_side.sv =====
// One address side (source or destination): burst clipping and line advance.
// Depends on drab_pkg (side_t, mode codes, is_local).
`default_nettype none

module drab_side import drab_pkg::*; (
    input  side_t       cur_side,
    input  logic [1:0]  mode,
    input  logic [15:0] line_step,
    input  logic [15:0] line_width,
    input  logic [7:0]  full_burst,
    input  logic [31:0] limit,
    input  logic [31:0] count_left,
    output logic [7:0]  burst_len,
    output side_t       next_side
);

    logic [31:0] full32;
    logic [31:0] to_bound;
    logic [31:0] len_lim;
    logic [31:0] len;
    logic [31:0] left_dec;
    logic [31:0] step_addr;

    // Burst length: boundary on the main bus, then limit, then line remainder
    always_comb begin
        full32   = {24'd0, full_burst};
        to_bound = is_local(cur_side.cur) ? full32
                                          : full32 - (cur_side.cur & (full32 - 32'd1));
        len_lim  = (limit < to_bound) ? limit : to_bound;
        len      = (cur_side.left < len_lim) ? cur_side.left : len_lim;
        burst_len = len[7:0];
    end

    // Advance address; at end of line jump according to mode
    always_comb begin
        left_dec  = cur_side.left - len;
        step_addr = cur_side.cur + len;
        next_side = cur_side;
        if (left_dec == 32'd0) begin
            case (mode)
                MODE_RECT: begin
                    next_side.cur  = cur_side.base + {16'd0, line_step};
                    next_side.left = {16'd0, line_width};
                end
                MODE_FIXED: begin
                    next_side.cur  = cur_side.base;
                    next_side.left = full32;
                end
                default: begin
                    next_side.cur  = step_addr;
                    next_side.left = count_left;
                end
            endcase
            next_side.base = next_side.cur;
        end else begin
            next_side.cur  = step_addr;
            next_side.left = left_dec;
        end
    end

endmodule

`default_nettype wire

// ===== dv/dma_rect_address_burst_gen_tb.sv =====
// Self-checking testbench for dma_rect_address_burst_gen: drives start/read/write requests,
// predicts every result with its own channel model and compares them field by field.
// Depends on drab_pkg and the RTL of dma_rect_address_burst_gen.

module dma_rect_address_burst_gen_tb;
    import drab_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int LONG_STALL     = 300;
    localparam int RANDOM_PHASES  = 8;

    typedef struct {
        logic [1:0]  cmd;
        logic [31:0] src;
        logic [31:0] dst;
        logic [31:0] count;
        logic [7:0]  buffered;
    } request_t;

    typedef struct {
        logic [1:0]  status;
        logic [7:0]  burst_bytes;
        logic [31:0] address;
        logic        on_local;
        logic        reads_finished;
        logic [31:0] remaining;
        logic        done;
    } burst_result_t;

    typedef struct {
        logic [1:0]  burst_code;
        logic        wide;
        logic [1:0]  src_mode;
        logic [1:0]  dst_mode;
        logic        rect_en;
        logic [15:0] line_width;
        logic [15:0] src_step;
        logic [15:0] dst_step;
    } dma_config_t;

    // DUT signals; the inputs are known from time zero
    logic                 aclk          = 1'b0;
    logic                 aresetn       = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [103:0]         s_axis_tdata  = '0;  // start_source, start_dest, byte_count, buffered_bytes
    logic [1:0]           s_axis_tuser  = '0;  // command
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [79:0]          m_axis_tdata;        // burst_bytes, bus_address, on_local_bus,
                                               // reads_finished, bytes_remaining, transfer_done
    logic [1:0]           m_axis_tuser;        // status
    logic                 cfg_wr_en     = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index     = '0;
    logic [15:0]          cfg_data      = '0;

    // Stimulus and scoreboard
    request_t      pending_requests[$];
    burst_result_t expected_bursts[$];
    request_t      cur_req;
    int            mismatches     = 0;
    int            idle_odds      = 0;   // 0: no idling, else 1-in-N chance per cycle
    bit            long_stall_req = 1'b0;
    int            send_gap       = 0;
    int            stall_left     = 0;
    int            quiet_cycles   = 0;

    // Channel model state
    dma_config_t   active_cfg = '{default: '0};
    side_t         src_side   = '0;
    side_t         dst_side   = '0;
    logic [31:0]   count_left = '0;
    logic          read_done  = 1'b1;
    logic          chan_active = 1'b0;

    dma_rect_address_burst_gen i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ---------------- channel model ----------------

    function automatic logic [31:0] unit_size();
        return active_cfg.wide ? 32'd8 : 32'd4;
    endfunction

    function automatic logic [31:0] max_burst();
        return (32'd4 << active_cfg.burst_code) * unit_size();
    endfunction

    function automatic bit config_ok();
        if (active_cfg.burst_code == BURST_CODE_BAD) return 1'b0;
        if (active_cfg.burst_code == BURST_CODE_16 && active_cfg.wide) return 1'b0;
        if (active_cfg.src_mode == MODE_UNDEFINED || active_cfg.dst_mode == MODE_UNDEFINED)
            return 1'b0;
        if (active_cfg.src_mode == MODE_RECT || active_cfg.dst_mode == MODE_RECT) begin
            if (!active_cfg.rect_en) return 1'b0;
            if (active_cfg.line_width < unit_size()) return 1'b0;
            if (active_cfg.src_mode == MODE_RECT && active_cfg.src_step < active_cfg.line_width)
                return 1'b0;
            if (active_cfg.dst_mode == MODE_RECT && active_cfg.dst_step < active_cfg.line_width)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic bit local_window_hit(input logic [31:0] a);
        return (a >= LOCAL_LO_A && a <= LOCAL_HI_A) || (a >= LOCAL_LO_B && a <= LOCAL_HI_B);
    endfunction

    // Bytes on a fresh line for the given addressing mode
    function automatic logic [31:0] line_bytes(input logic [1:0] mode);
        if (mode == MODE_RECT) return {16'd0, active_cfg.line_width};
        if (mode == MODE_FIXED) return max_burst();
        return count_left;
    endfunction

    // Burst boundary on the main bus, then the caller's limit, then the line remainder
    function automatic logic [31:0] clip_burst(input logic [31:0] addr, input logic [31:0] limit,
                                               input logic [31:0] line_left);
        logic [31:0] b;
        b = max_burst();
        if (!local_window_hit(addr)) b = b - (addr & (b - 32'd1));
        if (limit < b) b = limit;
        if (line_left < b) b = line_left;
        return b;
    endfunction

    function automatic side_t walk_side(input side_t s, input logic [1:0] mode,
                                        input logic [15:0] step, input logic [31:0] b);
        s.left = s.left - b;
        if (s.left == 32'd0) begin
            if (mode == MODE_RECT) s.cur = s.base + {16'd0, step};
            else if (mode == MODE_FIXED) s.cur = s.base;
            else s.cur = s.cur + b;
            s.base = s.cur;
            s.left = line_bytes(mode);
        end else begin
            s.cur = s.cur + b;
        end
        return s;
    endfunction

    task automatic predict_burst(input request_t r);
        burst_result_t e;
        logic [31:0]   a;
        logic [31:0]   b;
        e = '{default: '0};
        e.status = STATUS_OK;
        a = '0;
        b = '0;
        if (r.cmd == CMD_START) begin
            // a start while a transfer runs is dropped silently
            if (!chan_active) begin
                if (!config_ok()) begin
                    e.status = STATUS_INVALID;
                end else begin
                    count_left    = r.count;
                    src_side.cur  = r.src;
                    src_side.base = r.src;
                    dst_side.cur  = r.dst;
                    dst_side.base = r.dst;
                    src_side.left = line_bytes(active_cfg.src_mode);
                    dst_side.left = line_bytes(active_cfg.dst_mode);
                    read_done     = 1'b0;
                    chan_active   = 1'b1;
                end
            end
        end else if (r.cmd == CMD_UNKNOWN) begin
            e.status = STATUS_INVALID;
        end else if (!chan_active) begin
            e.status = STATUS_INACTIVE;
        end else if (!config_ok()) begin
            e.status = STATUS_INVALID;
        end else if (r.cmd == CMD_READ) begin
            a = src_side.cur;
            b = clip_burst(a, count_left, src_side.left);
            src_side = walk_side(src_side, active_cfg.src_mode, active_cfg.src_step, b);
            if (b >= count_left) read_done = 1'b1;
            e.reads_finished = read_done;
        end else begin
            a = dst_side.cur;
            b = clip_burst(a, {24'd0, r.buffered}, dst_side.left);
            dst_side = walk_side(dst_side, active_cfg.dst_mode, active_cfg.dst_step, b);
            count_left = (b >= count_left) ? 32'd0 : count_left - b;
            if (count_left == 32'd0) begin
                e.done = 1'b1;
                chan_active = 1'b0;
            end
        end
        if (e.status == STATUS_OK && r.cmd != CMD_START) begin
            e.on_local = local_window_hit(a);
            if (e.on_local) a = a - LOCAL_REBASE;
            e.address = a;
            e.burst_bytes = b[7:0];
        end
        e.remaining = count_left;
        expected_bursts.push_back(e);
    endtask

    // ---------------- request driver ----------------

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) predict_burst(cur_req);
            if (!s_axis_tvalid || s_axis_tready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (idle_odds != 0 && $urandom_range(idle_odds - 1, 0) == 0) begin
                    send_gap = $urandom_range(11, 0);
                    s_axis_tvalid <= 1'b0;
                end else if (pending_requests.size() != 0) begin
                    cur_req = pending_requests.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser  <= cur_req.cmd;
                    s_axis_tdata  <= {cur_req.buffered, cur_req.count, cur_req.dst, cur_req.src};
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // ---------------- result monitor ----------------

    task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin
        burst_result_t want;
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_bursts.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual status %0d data %h",
                             $time, m_axis_tuser, m_axis_tdata);
                    mismatches++;
                end else begin
                    want = expected_bursts.pop_front();
                    check_field("status", 32'(want.status), 32'(m_axis_tuser));
                    check_field("burst_bytes", 32'(want.burst_bytes), 32'(m_axis_tdata[7:0]));
                    check_field("bus_address", want.address, m_axis_tdata[39:8]);
                    check_field("on_local_bus", 32'(want.on_local), 32'(m_axis_tdata[40]));
                    check_field("reads_finished", 32'(want.reads_finished),
                                32'(m_axis_tdata[41]));
                    check_field("bytes_remaining", want.remaining, m_axis_tdata[73:42]);
                    check_field("transfer_done", 32'(want.done), 32'(m_axis_tdata[74]));
                end
            end
            // backpressure: one long hold on request, otherwise random bursts
            if (long_stall_req) begin
                stall_left = LONG_STALL;
                long_stall_req = 1'b0;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else if (idle_odds != 0 && $urandom_range(idle_odds - 1, 0) == 0) begin
                stall_left = $urandom_range(11, 0);
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // ---------------- watchdog ----------------

    always @(posedge aclk) begin
        if (!aresetn || cfg_wr_en || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // ---------------- stimulus ----------------

    task automatic queue_request(input logic [1:0] cmd, input logic [31:0] src,
                                 input logic [31:0] dst, input logic [31:0] count,
                                 input logic [7:0] buffered);
        request_t r;
        r.cmd = cmd;
        r.src = src;
        r.dst = dst;
        r.count = count;
        r.buffered = buffered;
        pending_requests.push_back(r);
    endtask

    // Sender pauses until every request has its result
    task automatic wait_drained();
        do @(negedge aclk);
        while (pending_requests.size() != 0 || s_axis_tvalid || expected_bursts.size() != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
    endtask

    // Narrow registers get random upper bits, which the block must ignore
    task automatic write_config(input dma_config_t c);
        write_reg(CFG_BURST_CODE, {14'($urandom), c.burst_code});
        write_reg(CFG_WIDE_BUS, {15'($urandom), c.wide});
        write_reg(CFG_SOURCE_MODE, {14'($urandom), c.src_mode});
        write_reg(CFG_DEST_MODE, {14'($urandom), c.dst_mode});
        write_reg(CFG_RECT_ENABLE, {15'($urandom), c.rect_en});
        write_reg(CFG_LINE_WIDTH, c.line_width);
        write_reg(CFG_SRC_STEP, c.src_step);
        write_reg(CFG_DST_STEP, c.dst_step);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        active_cfg = c;
    endtask

    function automatic logic [31:0] random_address();
        case ($urandom_range(8, 0))
            0, 1: return $urandom;
            2: return LOCAL_LO_A - 32'd64 + $urandom_range(127, 0);
            3: return LOCAL_HI_A - 32'd63 + $urandom_range(127, 0);
            4: return LOCAL_LO_B - 32'd64 + $urandom_range(127, 0);
            5: return LOCAL_HI_B - 32'd63 + $urandom_range(127, 0);
            6: return 32'hffff_ff80 + $urandom_range(127, 0);
            7: return LOCAL_LO_A + $urandom_range(32'h000f_ffff, 0);
            default: return $urandom_range(4095, 0);
        endcase
    endfunction

    function automatic logic [15:0] random_step(input logic [15:0] width);
        int s;
        case ($urandom_range(3, 0))
            0: return width;
            1: return 16'hffff;
            default: begin
                s = int'(width) + $urandom_range(300, 0);
                return (s > 65535) ? 16'hffff : 16'(s);
            end
        endcase
    endfunction

    // Break a valid setting in one of the ways the block must reject
    function automatic dma_config_t spoil_config(input dma_config_t c, input int kind);
        case (kind)
            0: c.burst_code = BURST_CODE_BAD;
            1: begin
                c.burst_code = BURST_CODE_16;
                c.wide = 1'b1;
            end
            2: c.src_mode = MODE_UNDEFINED;
            3: begin
                c.dst_mode = MODE_RECT;
                c.rect_en = 1'b0;
            end
            4: begin
                c.src_mode = MODE_RECT;
                c.rect_en = 1'b1;
                c.line_width = 16'd0;
            end
            5: begin
                c.dst_mode = MODE_RECT;
                c.rect_en = 1'b1;
                c.line_width = c.wide ? 16'd7 : 16'd3;
            end
            6: begin
                c.src_mode = MODE_RECT;
                c.rect_en = 1'b1;
                c.src_step = c.line_width - 16'd1;
            end
            7: begin
                c.dst_mode = MODE_RECT;
                c.rect_en = 1'b1;
                c.dst_step = 16'd0;
            end
            default: c.dst_mode = MODE_UNDEFINED;
        endcase
        return c;
    endfunction

    function automatic dma_config_t random_config(input bit allow_bad);
        dma_config_t c;
        int unsigned w;
        c.burst_code = 2'($urandom_range(2, 0));
        c.wide = 1'($urandom_range(1, 0));
        if (c.burst_code == BURST_CODE_16) c.wide = 1'b0;
        c.src_mode = 2'($urandom_range(2, 0));
        c.dst_mode = 2'($urandom_range(2, 0));
        if (c.src_mode == MODE_RECT || c.dst_mode == MODE_RECT) c.rect_en = 1'b1;
        else c.rect_en = 1'($urandom_range(1, 0));
        w = c.wide ? 8 : 4;
        case ($urandom_range(4, 0))
            0: c.line_width = 16'(w);
            1: c.line_width = 16'($urandom_range(65535, 1000));
            default: c.line_width = 16'($urandom_range(160, w));
        endcase
        c.src_step = random_step(c.line_width);
        c.dst_step = random_step(c.line_width);
        if (allow_bad && $urandom_range(5, 0) == 0) c = spoil_config(c, $urandom_range(8, 0));
        return c;
    endfunction

    // A start followed by a mix of read and write bursts, with some noise
    task automatic queue_transfer(input logic [31:0] total, input int bursts);
        logic [7:0] buffered;
        queue_request(CMD_START, random_address(), random_address(), total, 8'($urandom));
        repeat (bursts) begin
            case ($urandom_range(9, 0))
                0: buffered = 8'd0;
                1: buffered = 8'($urandom_range(255, 129));
                default: buffered = 8'($urandom_range(128, 1));
            endcase
            case ($urandom_range(19, 0))
                0: queue_request(CMD_UNKNOWN, $urandom, $urandom, $urandom, 8'($urandom));
                1: queue_request(CMD_START, random_address(), random_address(),
                                 $urandom_range(600, 0), 8'($urandom));
                2, 3, 4, 5, 6, 7, 8:
                    queue_request(CMD_READ, $urandom, $urandom, $urandom, 8'($urandom));
                default: queue_request(CMD_WRITE, $urandom, $urandom, $urandom, buffered);
            endcase
        end
    endtask

    // Finish a transfer still in flight with full write bursts
    task automatic drain_channel();
        int rounds;
        rounds = 0;
        while (chan_active && rounds < 40) begin
            repeat (6) queue_request(CMD_WRITE, $urandom, $urandom, $urandom, 8'd128);
            wait_drained();
            rounds++;
        end
    endtask

    function automatic logic [31:0] random_total();
        return ($urandom_range(4, 0) == 0) ? $urandom_range(16, 0) : $urandom_range(600, 17);
    endfunction

    initial begin
        dma_config_t base;
        dma_config_t c;
        int made;
        int n;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed requests on the reset setting: linear, 16-byte bursts
        idle_odds = 4;
        queue_request(CMD_READ, $urandom, $urandom, $urandom, 8'($urandom));
        queue_request(CMD_WRITE, $urandom, $urandom, $urandom, 8'($urandom));
        queue_request(CMD_UNKNOWN, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 8'hff);
        queue_request(CMD_START, LOCAL_LO_A - 32'd8, LOCAL_HI_A - 32'd3, 32'd60, 8'd0);
        queue_request(CMD_READ, '0, '0, '0, 8'd0);
        queue_request(CMD_READ, '0, '0, '0, 8'd0);
        queue_request(CMD_WRITE, '0, '0, '0, 8'd0);           // zero-length burst
        queue_request(CMD_WRITE, '0, '0, '0, 8'd255);
        queue_request(CMD_START, $urandom, $urandom, $urandom, 8'($urandom)); // while active
        queue_request(CMD_READ, '0, '0, '0, 8'd0);
        repeat (4) queue_request(CMD_WRITE, '0, '0, '0, 8'd128);
        queue_request(CMD_START, 32'hffff_ffff, 32'd0, 32'd0, 8'd0);  // empty transfer
        queue_request(CMD_READ, '0, '0, '0, 8'd0);
        queue_request(CMD_WRITE, '0, '0, '0, 8'd7);
        queue_request(CMD_START, 32'hffff_fff0, LOCAL_HI_B - 32'd5, 32'd33, 8'd0);
        repeat (2) queue_request(CMD_READ, '0, '0, '0, 8'd0);
        repeat (3) queue_request(CMD_WRITE, '0, '0, '0, 8'd128);
        wait_drained();
        drain_channel();

        // Rectangular on both sides, wide bus, narrowest line
        base = '{burst_code: BURST_CODE_8, wide: 1'b1, src_mode: MODE_RECT,
                 dst_mode: MODE_RECT, rect_en: 1'b1, line_width: 16'd8,
                 src_step: 16'd8, dst_step: 16'hffff};
        write_config(base);
        queue_transfer(32'd100, 16);
        wait_drained();
        drain_channel();

        // Fixed source, rectangular destination with the widest line
        base = '{burst_code: BURST_CODE_16, wide: 1'b0, src_mode: MODE_FIXED,
                 dst_mode: MODE_RECT, rect_en: 1'b1, line_width: 16'hffff,
                 src_step: 16'd0, dst_step: 16'hffff};
        write_config(base);
        queue_transfer(32'd90, 12);
        wait_drained();
        drain_channel();

        // Every way of breaking the setting, seen at start
        base = '{burst_code: BURST_CODE_4, wide: 1'b0, src_mode: MODE_LINEAR,
                 dst_mode: MODE_LINEAR, rect_en: 1'b1, line_width: 16'd16,
                 src_step: 16'd32, dst_step: 16'd32};
        for (int k = 0; k < 9; k++) begin
            write_config(spoil_config(base, k));
            queue_request(CMD_START, random_address(), random_address(), 32'd40, 8'd0);
            queue_request(CMD_READ, '0, '0, '0, 8'd0);
            queue_request(CMD_WRITE, '0, '0, '0, 8'd64);
            wait_drained();
        end

        // Setting broken while a transfer runs: bursts are rejected
        write_config(base);
        queue_request(CMD_START, random_address(), random_address(), 32'd300, 8'd0);
        queue_request(CMD_READ, '0, '0, '0, 8'd0);
        wait_drained();
        write_config(spoil_config(base, 0));
        queue_request(CMD_READ, '0, '0, '0, 8'd0);
        queue_request(CMD_WRITE, '0, '0, '0, 8'd64);
        wait_drained();
        write_config(base);
        drain_channel();

        // Random phases, each under its own setting and idling level
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            write_config(random_config(!chan_active));
            case ($urandom_range(3, 0))
                0: idle_odds = 0;
                1: idle_odds = 3;
                2: idle_odds = 6;
                default: idle_odds = 16;
            endcase
            if (p == 2) long_stall_req = 1'b1;
            made = 0;
            while (made < 55) begin
                n = $urandom_range(20, 4);
                queue_transfer(random_total(), n);
                made += n + 1;
            end
            wait_drained();
            drain_channel();
        end

        // Last part without idling, ending on a transfer too long to finish
        idle_odds = 0;
        write_config(random_config(1'b0));
        queue_transfer(random_total(), 20);
        wait_drained();
        drain_channel();
        queue_transfer(32'hffff_ff00 | $urandom, 25);
        wait_drained();
        repeat (10) @(negedge aclk);

        if (mismatches == 0 && expected_bursts.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
